>>> hw/rtl/b2da_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b2da_pkg;

	localparam int VALUE_BITS = 64;
	localparam int IN_BYTES   = (VALUE_BITS + 7) / 8;
	localparam int IN_TDATA_W = IN_BYTES * 8;

	// decimal digits needed for VALUE_BITS bits: floor(bits * log10(2)) + 1
	localparam int BCD_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BCD_BITS   = BCD_DIGITS * 4;

	localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
	localparam int DIG_CNT_W  = $clog2(BCD_DIGITS + 1);

	localparam int CHAR_W     = 6;
	localparam int OUT_TDATA_W = 8;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

endpackage

`default_nettype wire

>>> hw/rtl/b2da_dabble.sv
`timescale 1ns / 1ps
`default_nettype none

module b2da_dabble (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [b2da_pkg::VALUE_BITS-1:0]   value,
	output logic                                   done,
	output logic [b2da_pkg::BCD_BITS-1:0]          bcd
);

	logic [b2da_pkg::VALUE_BITS-1:0] bin_q;
	logic [b2da_pkg::BCD_BITS-1:0]   bcd_q;
	logic [b2da_pkg::BCD_BITS-1:0]   adj;
	logic [b2da_pkg::BIT_CNT_W-1:0]  cnt_q;
	logic                            busy_q;
	logic                            done_q;

	// add three to every digit of five or more before the shift
	always_comb begin
		logic [3:0] d;
		d = '0;
		adj = bcd_q;
		for (int i = 0; i < b2da_pkg::BCD_DIGITS; i++) begin
			d = bcd_q[4*i +: 4];
			adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == b2da_pkg::BIT_CNT_W'(b2da_pkg::VALUE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[b2da_pkg::VALUE_BITS-2:0], 1'b0};
			bcd_q <= {adj[b2da_pkg::BCD_BITS-2:0], bin_q[b2da_pkg::VALUE_BITS-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

`default_nettype wire

>>> hw/rtl/binary_to_decimal_ascii.sv
// Binary to decimal ASCII text converter.
// Input stream s_*: one transfer carries one unsigned 64-bit value in s_tdata.
// Output stream m_*: one transfer per decimal digit, most significant first,
// ASCII code in m_tdata[5:0], m_tlast set on the final digit. Leading zeros
// are dropped; zero gives the single character '0'.
// One value is in flight at a time: s_tready is high only while idle.
// After a value is taken, a bit-serial double-dabble core shifts in one bit
// per cycle and hands the BCD word over, then leading zero digits are
// shifted out one per cycle, and the digits follow, one per cycle while
// m_tready is high.
// A stalled receiver holds the current digit on m_tdata/m_tlast unchanged.
// Reset clears all control state; the block comes up idle and ready.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_ascii (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [b2da_pkg::IN_TDATA_W-1:0]      s_tdata,  // [63:0] value
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [b2da_pkg::OUT_TDATA_W-1:0]          m_tdata,  // [5:0] digit_char, [7:6] zero
	output logic                                      m_tlast   // last_digit
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_TRIM,
		ST_EMIT
	} state_t;

	state_t                          state_q;
	logic [b2da_pkg::BCD_BITS-1:0]   dig_q;
	logic [b2da_pkg::DIG_CNT_W-1:0]  left_q;
	logic                            in_xfer;
	logic                            out_xfer;
	logic                            conv_done;
	logic [b2da_pkg::BCD_BITS-1:0]   conv_bcd;
	logic [3:0]                      top_dig;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;
	assign top_dig  = dig_q[b2da_pkg::BCD_BITS-1 -: 4];

	b2da_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_xfer),
		.value  (s_tdata[b2da_pkg::VALUE_BITS-1:0]),
		.done   (conv_done),
		.bcd    (conv_bcd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			left_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) state_q <= ST_CONV;
				end
				ST_CONV: begin
					if (conv_done) begin
						left_q  <= b2da_pkg::DIG_CNT_W'(b2da_pkg::BCD_DIGITS);
						state_q <= ST_TRIM;
					end
				end
				ST_TRIM: begin
					if (top_dig == 4'd0 && left_q > b2da_pkg::DIG_CNT_W'(1)) begin
						left_q <= left_q - 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_xfer) begin
						left_q <= left_q - 1'b1;
						if (left_q == b2da_pkg::DIG_CNT_W'(1)) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// digit shift line: load from the core, advance on trim and on each transfer
	always_ff @(posedge clk) begin
		if (state_q == ST_CONV && conv_done) begin
			dig_q <= conv_bcd;
		end else if ((state_q == ST_TRIM && top_dig == 4'd0 && left_q > b2da_pkg::DIG_CNT_W'(1))
				|| (state_q == ST_EMIT && out_xfer)) begin
			dig_q <= {dig_q[b2da_pkg::BCD_BITS-5:0], 4'd0};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tdata  = {2'b00, b2da_pkg::ASCII_ZERO + {2'b00, top_dig}};
	assign m_tlast  = (left_q == b2da_pkg::DIG_CNT_W'(1));

endmodule

`default_nettype wire

>>> hw/rtl/b2da_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module b2da_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tvalid,
	input wire logic                             s_tready,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [b2da_pkg::OUT_TDATA_W-1:0] m_tdata,
	input wire logic                             m_tlast
);

	// hold a stalled digit
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output transfer changed");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while digits still pending");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && !m_tvalid)
		else $error("block not busy after input transfer");

	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
		else $error("block not idle after final digit");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:4] == 4'b0011 && m_tdata[3:0] <= 4'd9)
		else $error("output is not a decimal digit character");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import b2da_pkg::*;

	localparam int LIMIT         = 400000;
	localparam int DIRECTED      = 21;
	localparam int RANDOM_VALUES = 310;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last_digit;
	} digit_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   m_tready = 1'b0;
	logic                   s_tready;
	logic                   m_tvalid;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;

	digit_t pending_digits[$];
	int     fails        = 0;
	int     cycles       = 0;
	int     values_sent  = 0;
	int     digits_seen  = 0;
	int     longest_text = 0;
	bit     no_gaps      = 1'b0;

	logic [63:0] dir_value [DIRECTED] = '{
		64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
		64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
		64'd10000000000000000000, 64'd9999999999999999999,
		64'hFFFF_FFFF, 64'h1_0000_0000,
		64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
		64'd123456789, 64'd1000, 64'd1234567890123456789,
		64'hDEAD_BEEF_0123_4567, 64'd255, 64'd256
	};
	string dir_text [DIRECTED] = '{
		"0", "1", "9", "10", "99", "",
		"18446744073709551615", "9223372036854775808", "9223372036854775807",
		"10000000000000000000", "9999999999999999999",
		"4294967295", "4294967296",
		"", "",
		"123456789", "1000", "1234567890123456789",
		"", "255", "256"
	};

	binary_to_decimal_ascii dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [63:0] value
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [5:0] digit_char, [7:6] zero
		.m_tlast  (m_tlast)    // last_digit
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void predict_digits(input logic [63:0] value);
		logic [63:0] rem;
		logic [3:0]  lsd_first [20];
		int          n;
		digit_t      d;
		rem = value;
		n = 0;
		do begin
			lsd_first[n] = 4'(rem % 64'd10);
			rem = rem / 64'd10;
			n++;
		end while (rem != 64'd0);
		for (int k = n - 1; k >= 0; k--) begin
			d.digit_char = ASCII_ZERO + CHAR_W'(lsd_first[k]);
			d.last_digit = (k == 0);
			pending_digits.push_back(d);
		end
		if (n > longest_text)
			longest_text = n;
	endfunction

	function automatic void queue_text(input string text);
		digit_t d;
		for (int i = 0; i < text.len(); i++) begin
			d.digit_char = CHAR_W'(text[i]);
			d.last_digit = (i == text.len() - 1);
			pending_digits.push_back(d);
		end
		if (text.len() > longest_text)
			longest_text = text.len();
	endfunction

	task automatic send_value(input logic [63:0] v, input string text);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (s_tready !== 1'b1);
		if (text.len() != 0)
			queue_text(text);
		else
			predict_digits(v);
		values_sent++;
	endtask

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("testbench failed");
		$finish;
	end

	initial begin
		int     stall;
		digit_t want;
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			digits_seen++;
			if (pending_digits.size() == 0) begin
				$error("unexpected digit transfer: m_tdata=%0d m_tlast=%0b", m_tdata, m_tlast);
				fails++;
			end else begin
				want = pending_digits.pop_front();
				if (m_tdata[CHAR_W-1:0] !== want.digit_char) begin
					$error("digit_char: expected %0d, got %0d",
						want.digit_char, m_tdata[CHAR_W-1:0]);
					fails++;
				end
				if (m_tlast !== want.last_digit) begin
					$error("last_digit: expected %0b, got %0b", want.last_digit, m_tlast);
					fails++;
				end
				if (m_tdata[OUT_TDATA_W-1:CHAR_W] !== '0) begin
					$error("tdata pad: expected 0, got %0d", m_tdata[OUT_TDATA_W-1:CHAR_W]);
					fails++;
				end
			end
		end
	end

	initial begin
		logic [63:0] v;
		logic [63:0] p;
		int          kind;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED; i++)
			send_value(dir_value[i], dir_text[i]);

		for (int i = 0; i < RANDOM_VALUES; i++) begin
			no_gaps = ((i / 40) % 3 == 1);
			if (i == RANDOM_VALUES / 2) begin
				// hold until the converter has drained
				s_tvalid <= 1'b0;
				while (pending_digits.size() != 0) @(posedge clk);
			end
			v = {$urandom(), $urandom()};
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2, 3, 4: v = v >> $urandom_range(0, 63);
				7: begin
					p = 64'd1;
					repeat ($urandom_range(0, 19)) p = p * 64'd10;
					v = p + 64'($urandom_range(0, 2)) - 64'd1;
				end
				8: v = 64'($urandom_range(0, 20));
				9: v = 64'hFFFF_FFFF_FFFF_FFFF >> $urandom_range(0, 63);
				default: ;
			endcase
			send_value(v, "");
		end
		s_tvalid <= 1'b0;

		while (pending_digits.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("Converted %0d values (%0d directed, %0d random) into %0d digit transfers.",
			values_sent, DIRECTED, RANDOM_VALUES, digits_seen);
		$display("Longest decimal text: %0d digits; sender and receiver stalls of 0 to 5 cycles.",
			longest_text);
		if (fails == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
